FILE: sv/fdpp_pkg.sv
// ---------------------------------------------------------------------------
// fdpp_pkg
// Shared types and constants of the framed decimal packet parser.
// ---------------------------------------------------------------------------
`default_nettype none

package fdpp_pkg;

   // request commands
   localparam logic [1:0] CMD_BYTE = 2'd0;
   localparam logic [1:0] CMD_TAKE = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   // flag selection of a take request
   localparam logic [1:0] TAKE_BRIGHT = 2'd0;
   localparam logic [1:0] TAKE_TIME   = 2'd1;
   localparam logic [1:0] TAKE_TEXT   = 2'd2;

   // ready flag bit positions
   localparam int FLAG_BRIGHT = 0;
   localparam int FLAG_TIME   = 1;
   localparam int FLAG_TEXT   = 2;

   // characters
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam int TEXT_AW     = 7;
   localparam int TEXT_DEPTH  = 128;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] rx_byte;
      logic [1:0] packet_kind;
      logic [6:0] text_index;
   } req_type;

   typedef struct packed {
      logic signed [15:0] brightness_value;
      logic signed [15:0] time_value;
      logic [2:0]         ready_flags;
      logic               flag_was_set;
      logic [7:0]         text_byte;
      logic [6:0]         text_length;
   } rsp_type;

   // request plus its byte classification
   typedef struct packed {
      req_type req;
      logic    is_blank;
      logic    is_digit;
      logic    is_plus;
      logic    is_minus;
      logic    is_at;
      logic    is_hash;
      logic    is_amp;
      logic    is_pct;
      logic    is_nl;
   } op_type;

endpackage

`default_nettype wire

FILE: sv/framed_decimal_packet_parser.sv
// A request passes the request queue and then the response register on its way to rsp_data.
// Throughput: one request per cycle while rsp_stall does not hold the response register.
// A two-entry request queue lets the front keep accepting while a response is stalled.
// Reset clears framing, flags, counts and stored numbers; the text memory is not cleared.
// ---------------------------------------------------------------------------
// framed_decimal_packet_parser
// Finds header/body/'%'/newline packets in received bytes, converts numbers, keeps text.
// ---------------------------------------------------------------------------
`default_nettype none

module framed_decimal_packet_parser
   import fdpp_pkg::*;
#(
   parameter int PACKET_BYTES = 128
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic   op_valid;
   op_type op;
   logic   op_pop;

   fdpp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .op_valid  (op_valid),
      .op        (op),
      .op_pop    (op_pop)
   );

   fdpp_back #(
      .PACKET_BYTES (PACKET_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (op_valid),
      .op        (op),
      .op_pop    (op_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: sv/fdpp_front.sv
// ---------------------------------------------------------------------------
// fdpp_front
// Accepts requests, classifies the received byte and queues the result.
// ---------------------------------------------------------------------------
`default_nettype none

module fdpp_front
   import fdpp_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_stall,
   input  wire req_type req_data,
   output logic        op_valid,
   output op_type      op,
   input  wire logic   op_pop
);

   op_type     cls;
   op_type     queue_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   always_comb begin
      cls          = '0;
      cls.req      = req_data;
      cls.is_blank = (req_data.rx_byte == CH_SPACE) ||
                     ((req_data.rx_byte >= CH_TAB) && (req_data.rx_byte <= CH_CR));
      cls.is_digit = (req_data.rx_byte >= CH_ZERO) && (req_data.rx_byte <= CH_NINE);
      cls.is_plus  = req_data.rx_byte == CH_PLUS;
      cls.is_minus = req_data.rx_byte == CH_MINUS;
      cls.is_at    = req_data.rx_byte == CH_AT;
      cls.is_hash  = req_data.rx_byte == CH_HASH;
      cls.is_amp   = req_data.rx_byte == CH_AMP;
      cls.is_pct   = req_data.rx_byte == CH_PCT;
      cls.is_nl    = req_data.rx_byte == CH_NL;
   end

   assign req_stall = count_ff == 2'(QUEUE_DEPTH);
   assign push      = req_valid && !req_stall;
   assign op_valid  = count_ff != 2'd0;
   assign op        = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push   ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = op_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(op_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cls;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QUEUE_DEPTH))
      else $error("request queue over depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      op_pop |-> count_ff != 2'd0)
      else $error("pop from empty request queue");

   a_head_held: assert property (@(posedge clock) disable iff (reset)
      op_valid && !op_pop |=> op_valid && $stable(op))
      else $error("queue head changed while waiting");

endmodule

`default_nettype wire

FILE: sv/fdpp_back.sv
// ---------------------------------------------------------------------------
// fdpp_back
// Executes queued requests: framing, number conversion, text store, flags.
// ---------------------------------------------------------------------------
`default_nettype none

module fdpp_back
   import fdpp_pkg::*;
#(
   parameter int PACKET_BYTES = 128
)
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   op_valid,
   input  wire op_type op,
   output logic        op_pop,
   output logic        rsp_valid,
   input  wire logic   rsp_stall,
   output rsp_type     rsp_data
);

   localparam int BODY_LIMIT = PACKET_BYTES - 1;
   localparam int BW         = $clog2(PACKET_BYTES);
   localparam int TEXT_LIMIT = (BODY_LIMIT < 127) ? BODY_LIMIT : 127;
   localparam logic [BW-1:0]      BODY_MAX = BW'(BODY_LIMIT);
   localparam logic [TEXT_AW-1:0] TEXT_MAX = TEXT_AW'(TEXT_LIMIT);

   localparam logic [1:0] FR_IDLE = 2'd0;
   localparam logic [1:0] FR_BODY = 2'd1;
   localparam logic [1:0] FR_TAIL = 2'd2;

   localparam logic [1:0] CUR_NONE   = 2'd0;
   localparam logic [1:0] CUR_BRIGHT = 2'd1;
   localparam logic [1:0] CUR_TIME   = 2'd2;
   localparam logic [1:0] CUR_TEXT   = 2'd3;

   localparam logic [1:0] NP_SKIP   = 2'd0;
   localparam logic [1:0] NP_DIGITS = 2'd1;
   localparam logic [1:0] NP_DONE   = 2'd2;

   logic [1:0]         frame_state_ff, frame_state_in;
   logic [1:0]         kind_ff, kind_in;
   logic [BW-1:0]      body_count_ff, body_count_in;
   logic [1:0]         phase_ff, phase_in;
   logic               negative_ff, negative_in;
   logic [15:0]        accum_ff, accum_in;
   logic [15:0]        bright_ff, bright_in;
   logic [15:0]        time_ff, time_in;
   logic [2:0]         ready_ff, ready_in;
   logic [TEXT_AW-1:0] text_count_ff, text_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff;
   logic               rsp_hit_ff;
   logic [7:0]         text_rd_ff;
   logic [7:0]         text_mem [TEXT_DEPTH];

   logic               exec;
   logic               mem_we;
   logic               rd_hit;
   logic               was_set;
   logic [15:0]        accum_next;
   logic [15:0]        number_value;

   assign exec   = op_valid && (!rsp_valid_ff || !rsp_stall);
   assign op_pop = exec;

   // value * 10 + digit, wrapping
   assign accum_next   = {accum_ff[12:0], 3'b000} + {accum_ff[14:0], 1'b0} +
                         {12'd0, op.req.rx_byte[3:0]};
   assign number_value = negative_ff ? 16'(16'd0 - accum_ff) : accum_ff;

   always_comb begin
      frame_state_in = frame_state_ff;
      kind_in        = kind_ff;
      body_count_in  = body_count_ff;
      phase_in       = phase_ff;
      negative_in    = negative_ff;
      accum_in       = accum_ff;
      bright_in      = bright_ff;
      time_in        = time_ff;
      ready_in       = ready_ff;
      text_count_in  = text_count_ff;
      mem_we         = 1'b0;
      rd_hit         = 1'b0;
      was_set        = 1'b0;
      if (exec) begin
         unique case (op.req.command)
            CMD_BYTE: begin
               unique case (frame_state_ff)
                  FR_BODY: begin
                     priority if (op.is_pct) begin
                        frame_state_in = FR_TAIL;
                     end else if (kind_ff == CUR_TEXT) begin
                        if (text_count_ff < TEXT_MAX) begin
                           mem_we        = 1'b1;
                           text_count_in = text_count_ff + TEXT_AW'(1);
                        end
                     end else if (body_count_ff < BODY_MAX) begin
                        body_count_in = body_count_ff + BW'(1);
                        unique case (phase_ff)
                           NP_SKIP: begin
                              priority if (op.is_blank) begin
                                 phase_in = NP_SKIP;
                              end else if (op.is_plus || op.is_minus) begin
                                 negative_in = op.is_minus;
                                 phase_in    = NP_DIGITS;
                              end else if (op.is_digit) begin
                                 accum_in = {12'd0, op.req.rx_byte[3:0]};
                                 phase_in = NP_DIGITS;
                              end else begin
                                 phase_in = NP_DONE;
                              end
                           end
                           NP_DIGITS: begin
                              if (op.is_digit) begin
                                 accum_in = accum_next;
                              end else begin
                                 phase_in = NP_DONE;
                              end
                           end
                           default: begin
                           end
                        endcase
                     end else begin
                        // number body full, byte dropped
                     end
                  end
                  FR_TAIL: begin
                     if (op.is_nl) begin
                        frame_state_in = FR_IDLE;
                        unique case (kind_ff)
                           CUR_BRIGHT: begin
                              bright_in             = number_value;
                              ready_in[FLAG_BRIGHT] = 1'b1;
                           end
                           CUR_TIME: begin
                              time_in             = number_value;
                              ready_in[FLAG_TIME] = 1'b1;
                           end
                           CUR_TEXT: begin
                              ready_in[FLAG_TEXT] = 1'b1;
                           end
                           default: begin
                           end
                        endcase
                     end
                  end
                  default: begin
                     // idle, also the unused frame code
                     frame_state_in = FR_IDLE;
                     priority if (op.is_at && !ready_ff[FLAG_BRIGHT]) begin
                        kind_in = CUR_BRIGHT;
                     end else if (op.is_hash && !ready_ff[FLAG_TIME]) begin
                        kind_in = CUR_TIME;
                     end else if (op.is_amp && !ready_ff[FLAG_TEXT]) begin
                        kind_in = CUR_TEXT;
                     end else begin
                        kind_in = kind_ff;
                     end
                     if ((op.is_at && !ready_ff[FLAG_BRIGHT]) ||
                         (op.is_hash && !ready_ff[FLAG_TIME]) ||
                         (op.is_amp && !ready_ff[FLAG_TEXT])) begin
                        frame_state_in = FR_BODY;
                        body_count_in  = '0;
                        phase_in       = NP_SKIP;
                        negative_in    = 1'b0;
                        accum_in       = 16'd0;
                        if (op.is_amp) begin
                           text_count_in = '0;
                        end
                     end
                  end
               endcase
            end
            CMD_TAKE: begin
               unique case (op.req.packet_kind)
                  TAKE_BRIGHT: begin
                     was_set               = ready_ff[FLAG_BRIGHT];
                     ready_in[FLAG_BRIGHT] = 1'b0;
                  end
                  TAKE_TIME: begin
                     was_set             = ready_ff[FLAG_TIME];
                     ready_in[FLAG_TIME] = 1'b0;
                  end
                  TAKE_TEXT: begin
                     was_set             = ready_ff[FLAG_TEXT];
                     ready_in[FLAG_TEXT] = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
            CMD_READ: begin
               rd_hit = op.req.text_index < text_count_ff;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid_in = exec || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_state_ff <= FR_IDLE;
         kind_ff        <= CUR_NONE;
         body_count_ff  <= '0;
         phase_ff       <= NP_SKIP;
         negative_ff    <= 1'b0;
         accum_ff       <= 16'd0;
         bright_ff      <= 16'd0;
         time_ff        <= 16'd0;
         ready_ff       <= 3'd0;
         text_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         frame_state_ff <= frame_state_in;
         kind_ff        <= kind_in;
         body_count_ff  <= body_count_in;
         phase_ff       <= phase_in;
         negative_ff    <= negative_in;
         accum_ff       <= accum_in;
         bright_ff      <= bright_in;
         time_ff        <= time_in;
         ready_ff       <= ready_in;
         text_count_ff  <= text_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // response register and text store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         text_mem[text_count_ff] <= op.req.rx_byte;
      end
      if (exec) begin
         text_rd_ff                <= text_mem[op.req.text_index];
         rsp_hit_ff                <= rd_hit;
         rsp_ff.brightness_value   <= bright_in;
         rsp_ff.time_value         <= time_in;
         rsp_ff.ready_flags        <= ready_in;
         rsp_ff.flag_was_set       <= was_set;
         rsp_ff.text_byte          <= 8'd0;
         rsp_ff.text_length        <= text_count_in;
      end
   end

   always_comb begin
      rsp_data           = rsp_ff;
      rsp_data.text_byte = rsp_hit_ff ? text_rd_ff : 8'd0;
   end

   assign rsp_valid = rsp_valid_ff;

   a_text_bound: assert property (@(posedge clock) disable iff (reset)
      text_count_ff <= TEXT_MAX && frame_state_ff != 2'd3)
      else $error("text count or frame state out of range");

   a_text_complete: assert property (@(posedge clock) disable iff (reset)
      exec && op.req.command == CMD_BYTE && frame_state_ff == FR_TAIL && op.is_nl &&
      kind_ff == CUR_TEXT |=> ready_ff[FLAG_TEXT] && frame_state_ff == FR_IDLE)
      else $error("text packet completion missed");

   a_take_clears: assert property (@(posedge clock) disable iff (reset)
      exec && op.req.command == CMD_TAKE && op.req.packet_kind == TAKE_BRIGHT
      |=> !ready_ff[FLAG_BRIGHT] && !rsp_data.ready_flags[FLAG_BRIGHT])
      else $error("take left brightness flag set");

endmodule

`default_nettype wire
